// ===== sv/md5_message_digest_defines.svh =====
// Assertion macros for the digest block's RTL; included by md5_message_digest.sv.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MD5MD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define MD5MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/md5md_pkg.sv =====
// Package for the MD5 digest block: round constants, schedule functions
// and the structs passed between the sequencer, message store and compressor.
package md5md_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [1:0] WORD_LAST  = 2'd3;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  typedef enum logic [1:0] {
    RND_F = 2'd0,
    RND_G = 2'd1,
    RND_H = 2'd2,
    RND_I = 2'd3
  } rnd_grp_e;

  // Write port of the message store.
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } msg_wr_t;

  // Commands from the sequencer to the compressor.
  typedef struct packed {
    logic start;
    logic init;
  } cmp_cmd_t;

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    case (rnd_grp_e'(rnd[5:4]))
      RND_F:   g = i;
      RND_G:   g = 4'((i << 2) + i + 4'd1);
      RND_H:   g = 4'((i << 1) + i + 4'd5);
      RND_I:   g = 4'((i << 3) - i);
      default: g = i;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/md5md_msg_store.sv =====
// Message block store: sixteen 32-bit words filled one byte at a time,
// little-endian within a word, with a registered word read. Uses md5md_pkg.
module md5md_msg_store (
  input  logic               clk_i,
  input  md5md_pkg::msg_wr_t wr_i,
  input  logic [3:0]         raddr_i,
  output logic [31:0]        rdata_o
);
  import md5md_pkg::*;

  logic [31:0] mem_q [16];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[5:2]][{wr_i.addr[1:0], 3'b000} +: 8] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/md5md_compress.sv =====
// MD5 compression: one shared round unit stepped over 64 rounds, then the
// feed-forward into the chaining words. Uses md5md_pkg; reads md5md_msg_store.
module md5md_compress (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  md5md_pkg::cmp_cmd_t  cmd_i,
  input  logic [31:0]          rdata_i,
  output logic [3:0]           raddr_o,
  output logic                 done_o,
  output logic [3:0][31:0]     chain_o
);
  import md5md_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIN
  } cstate_e;

  cstate_e         st_q;
  logic [5:0]      rnd_q;
  logic [3:0][31:0] chain_q;
  logic [31:0]     a_q, b_q, c_q, d_q, t_q;
  logic [31:0]     f;
  logic [31:0]     sum;
  logic [63:0]     dbl;
  logic [31:0]     b_new;
  logic [5:0]      rnd_nx;

  assign rnd_nx = 6'(rnd_q + 6'd1);

  always_comb begin
    case (rnd_grp_e'(rnd_q[5:4]))
      RND_F:   f = (b_q & c_q) | (~b_q & d_q);
      RND_G:   f = (b_q & d_q) | (c_q & ~d_q);
      RND_H:   f = b_q ^ c_q ^ d_q;
      RND_I:   f = c_q ^ (b_q | ~d_q);
      default: f = b_q ^ c_q ^ d_q;
    endcase
  end

  // t_q already holds a + K for this round, so one three-input add remains.
  assign sum   = t_q + f + rdata_i;
  assign dbl   = {sum, sum} << rot_amount(rnd_q);
  assign b_new = b_q + dbl[63:32];

  // The store read is issued in the cycle before the round that uses it.
  assign raddr_o = (st_q == C_RUN) ? msg_index(rnd_nx) : msg_index(6'd0);
  assign done_o  = (st_q == C_FIN);
  assign chain_o = chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= C_IDLE;
      rnd_q   <= '0;
      chain_q <= {IV_D, IV_C, IV_B, IV_A};
    end else begin
      case (st_q)
        C_IDLE: begin
          if (cmd_i.init) begin
            chain_q <= {IV_D, IV_C, IV_B, IV_A};
          end
          if (cmd_i.start) begin
            st_q  <= C_RUN;
            rnd_q <= '0;
          end
        end
        C_RUN: begin
          rnd_q <= rnd_nx;
          if (rnd_q == BLOCK_LAST) begin
            st_q <= C_FIN;
          end
        end
        C_FIN: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          st_q       <= C_IDLE;
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == C_IDLE && cmd_i.start) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      t_q <= chain_q[0] + RoundK[0];
    end else if (st_q == C_RUN) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
      t_q <= d_q + RoundK[rnd_nx];
    end
  end

endmodule

// ===== sv/md5_message_digest.sv =====
// Throughput: one byte beat per cycle while idle; the beat that fills a block stalls input until compressed.
// End of message: padding is written one byte per cycle up to the block end, taking one
// or two compressions, then four digest beats follow on the output.
// The round unit in md5md_compress sets the block time: one round per cycle plus load and feed-forward.
// Reset (async, active low) restores the initial chaining words and clears the byte count.
`include "md5_message_digest_defines.svh"
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tuser_i,   // [0] byte_present
  input  logic        s_tlast_i,   // end_of_message
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [31:0] digest_word
  output logic [1:0]  m_tuser_o,   // [1:0] word_index
  output logic        m_tlast_o    // last_word
);
  import md5md_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMP,
    S_PAD,
    S_EMIT
  } state_e;

  state_e           state_q, ret_q;
  logic [63:0]      total_q;
  logic [63:0]      total_nx;
  logic [63:0]      bits;
  logic [5:0]       pos_q;
  logic             first_q, len_q, start_q;
  logic [1:0]       idx_q;
  msg_wr_t          wr;
  cmp_cmd_t         cmd;
  logic [3:0]       raddr;
  logic [31:0]      rdata;
  logic             done;
  logic [3:0][31:0] chain;
  logic             in_acc, out_acc;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = (state_q == S_EMIT);
  assign out_acc    = m_tvalid_o && m_tready_i;
  assign m_tdata_o  = chain[idx_q];
  assign m_tuser_o  = idx_q;
  assign m_tlast_o  = (idx_q == WORD_LAST);

  assign total_nx = s_tuser_i ? total_q + 64'd1 : total_q;
  assign bits     = {total_q[60:0], 3'b000};

  always_comb begin
    wr = '0;
    if (state_q == S_IDLE) begin
      wr.en   = in_acc && s_tuser_i;
      wr.addr = total_q[5:0];
      wr.data = s_tdata_i;
    end else if (state_q == S_PAD) begin
      wr.en   = 1'b1;
      wr.addr = pos_q;
      if (first_q) begin
        wr.data = PAD_BYTE;
      end else if (len_q) begin
        wr.data = bits[{pos_q[2:0], 3'b000} +: 8];
      end else begin
        wr.data = ZERO_BYTE;
      end
    end
  end

  assign cmd.start = start_q;
  assign cmd.init  = out_acc && (idx_q == WORD_LAST);

  md5md_msg_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md5md_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rdata_i (rdata),
    .raddr_o (raddr),
    .done_o  (done),
    .chain_o (chain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      total_q <= '0;
      pos_q   <= '0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      start_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            total_q <= total_nx;
            pos_q   <= total_nx[5:0];
            first_q <= 1'b1;
            len_q   <= 1'b0;
            if (s_tuser_i && total_q[5:0] == BLOCK_LAST) begin
              start_q <= 1'b1;
              state_q <= S_COMP;
              ret_q   <= s_tlast_i ? S_PAD : S_IDLE;
            end else if (s_tlast_i) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          first_q <= 1'b0;
          pos_q   <= 6'(pos_q + 6'd1);
          if (6'(pos_q + 6'd1) == LEN_POS) begin
            len_q <= 1'b1;
          end
          if (pos_q == BLOCK_LAST) begin
            start_q <= 1'b1;
            state_q <= S_COMP;
            ret_q   <= len_q ? S_EMIT : S_PAD;
          end
        end
        S_COMP: begin
          if (done) begin
            state_q <= ret_q;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            idx_q <= 2'(idx_q + 2'd1);
            if (idx_q == WORD_LAST) begin
              total_q <= '0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The input side is closed for as long as digest beats are on offer.
  `MD5MD_ASSERT(a_no_overlap, !(m_tvalid_o && s_tready_o), "input open during digest output")
  // The byte count starts again from zero once the last digest beat has gone.
  `MD5MD_ASSERT_NEXT(a_count_clear, out_acc && m_tlast_o, total_q == 64'd0, "byte count not cleared")
  // A byte landing in the final slot of a block always starts a compression.
  `MD5MD_ASSERT_NEXT(a_full_block, in_acc && s_tuser_i && (total_q[5:0] == BLOCK_LAST),
    (state_q == S_COMP) && start_q, "full block not compressed")

endmodule

// ===== sim/md5_digest_checker.sv =====
// Scoreboard for md5_message_digest: watches both stream channels, predicts the digest words
// from the accepted message bytes and compares them with the words that leave the block.
// Stand-alone; depends on nothing but the signals it is wired to.
`timescale 1ns / 1ps

module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_user_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  input  logic [1:0]  out_user_i,
  input  logic        out_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [7:0] PAD_FILL      = 8'h00;
  localparam logic [5:0] LEN_FIELD_POS = 6'd56;
  localparam logic [5:0] FINAL_SLOT    = 6'd63;
  localparam logic [1:0] FINAL_WORD    = 2'd3;

  localparam logic [31:0] INIT_WORD [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]  chain [4];
  logic [7:0]   block_bytes [64];
  logic [63:0]  msg_bytes;
  digest_beat_t digest_q [$];
  digest_beat_t want;

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int i, g, s;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = ROT[(i / 16) * 4 + i % 4];
      t = a + f + SINE_K[i] + w[g];
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = b + t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  // Writes one byte into the block and compresses once the block is full.
  function automatic logic [5:0] store_byte(input logic [5:0] pos, input logic [7:0] v);
    block_bytes[pos] = v;
    if (pos == FINAL_SLOT) compress_block();
    return pos + 6'd1;
  endfunction

  function automatic void absorb_beat(input logic [7:0] data, input logic present,
                                      input logic eom);
    logic [63:0]  bit_len;
    logic [5:0]   pos;
    int           k;
    digest_beat_t beat;
    if (present) begin
      pos = store_byte(msg_bytes[5:0], data);
      msg_bytes++;
    end
    if (!eom) return;
    bit_len = msg_bytes << 3;
    pos = store_byte(msg_bytes[5:0], PAD_MARK);
    while (pos != LEN_FIELD_POS) pos = store_byte(pos, PAD_FILL);
    for (k = 0; k < 8; k++) pos = store_byte(pos, bit_len[8*k +: 8]);
    for (k = 0; k < 4; k++) begin
      beat.word = chain[k];
      beat.idx  = 2'(k);
      beat.last = (2'(k) == FINAL_WORD);
      digest_q.push_back(beat);
    end
    chain     = INIT_WORD;
    msg_bytes = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain        = INIT_WORD;
      msg_bytes    = '0;
      digest_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) absorb_beat(in_data_i, in_user_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("digest beat 0x%08h arrived with no message ended", out_data_i);
          fail_count_o++;
        end else begin
          want = digest_q.pop_front();
          if (out_data_i !== want.word) begin
            $error("digest_word: expected 0x%08h, got 0x%08h", want.word, out_data_i);
            fail_count_o++;
          end
          if (out_user_i !== want.idx) begin
            $error("word_index: expected %0d, got %0d", want.idx, out_user_i);
            fail_count_o++;
          end
          if (out_last_i !== want.last) begin
            $error("last_word: expected %0b, got %0b", want.last, out_last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = digest_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the md5_message_digest testbench: clock, reset, message stimulus and back-pressure.
// Relies on md5_digest_checker for prediction and comparison, and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 400;
  localparam int MIN_MESSAGES = 13;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int FORCED_LEN [4]  = '{55, 56, 63, 64};
  localparam int EDGE_LEN   [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = '0;
  logic        s_tuser_i = 1'b0;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        m_tlast_o;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  always #10 clk_i = ~clk_i;

  md5_message_digest dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  md5_digest_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_i   (s_tready_o),
    .in_data_i    (s_tdata_i),
    .in_user_i    (s_tuser_i),
    .in_last_i    (s_tlast_i),
    .out_valid_i  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_data_i   (m_tdata_o),
    .out_user_i   (m_tuser_o),
    .out_last_i   (m_tlast_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The long hold-off is counted here so that the sender keeps offering beats meanwhile.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void apply_mode(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct = 62;
        stall_pct     = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        stall_pct     = 62;
      end
      IDLE_BOTH: begin
        send_idle_pct = 34;
        stall_pct     = 34;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endfunction

  task automatic offer_beat(input logic [7:0] data, input logic present, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= data;
    s_tuser_i  <= present;
    s_tlast_i  <= eom;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    if (present || eom) items_sent++;
  endtask

  // Stops offering and waits until every digest word predicted so far has left the block.
  task automatic drain_digests();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // A message of random bytes with empty beats scattered in; the end rides either on the
  // last byte or on a beat of its own.
  task automatic send_message(input int len);
    int n;
    bit end_with_byte;
    end_with_byte = (len > 0) && ($urandom_range(1) == 1);
    for (n = 0; n < len; n++) begin
      if ($urandom_range(9) == 0) offer_beat(8'($urandom), 1'b0, 1'b0);
      offer_beat(8'($urandom), 1'b1, end_with_byte && (n == len - 1));
    end
    if (!end_with_byte) offer_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length(input int msg_no);
    int r;
    if (msg_no < 4) return FORCED_LEN[msg_no];
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8);
    if (r < 88) return $urandom_range(40, 9);
    return EDGE_LEN[$urandom_range(9)];
  endfunction

  initial begin
    int msg_no;
    int base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_mode(IDLE_NONE);
    // Empty message, then a single zero byte carrying the end.
    offer_beat(8'h00, 1'b0, 1'b1);
    offer_beat(8'h00, 1'b1, 1'b1);
    // All-ones byte, an ignored beat, then an end with junk data that must not be absorbed.
    offer_beat(8'hff, 1'b1, 1'b0);
    offer_beat(8'h3c, 1'b0, 1'b0);
    offer_beat(8'h5a, 1'b0, 1'b1);
    offer_beat(8'h61, 1'b1, 1'b0);
    offer_beat(8'h62, 1'b1, 1'b0);
    offer_beat(8'h63, 1'b1, 1'b1);
    // An ignored beat at the start of a message must leave the count untouched.
    offer_beat(8'hc3, 1'b0, 1'b0);
    offer_beat(8'ha5, 1'b1, 1'b1);
    drain_digests();

    base   = items_sent;
    msg_no = 0;
    while (items_sent - base < RANDOM_ITEMS || msg_no < MIN_MESSAGES) begin
      if (msg_no == 12) drain_digests();
      if (msg_no == 6) begin
        apply_mode(IDLE_NONE);
        hold_req = 1'b1;
      end else if (msg_no < 4) begin
        apply_mode(idle_mode_e'(msg_no));
      end else if (msg_no % 3 == 0) begin
        apply_mode(idle_mode_e'((msg_no / 3) % 4));
      end
      send_message(pick_length(msg_no));
      msg_no++;
    end

    drain_digests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
